// File: src/dvc_pkg.sv
// Package for the distance/velocity controller: word types, register
// indexes, step counts and the control struct for the serial units.
// No dependencies.
package dvc_pkg;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;
   localparam int MUL_STEPS   = 16;
   localparam int ROOT_STEPS  = 17;
   localparam int CNT_W       = 5;

   localparam logic [CSR_INDEX_W-1:0] CSR_TARGET_X   = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_TARGET_Y   = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_GAIN_P     = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_GAIN_DAMP  = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_SPEED  = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_ARRIVE_THR = 3'd5;

   typedef struct packed {
      logic signed [15:0] cur_x;
      logic signed [15:0] cur_y;
   } dvc_req_type;

   typedef struct packed {
      logic signed [15:0] speed_cmd;
      logic        [16:0] distance;
      logic               arrived;
   } dvc_rsp_type;

   typedef struct packed {
      logic load;
      logic step;
   } dvc_seq_ctl_type;

endpackage

// File: src/distance_velocity_controller_core.sv
// Distance/velocity controller, top level.
// Depends on dvc_pkg, dvc_smul and dvc_sqrt.
//
// Usage:
//   req_*: position word (cur_x, cur_y), taken when req_valid && !req_stall.
//   rsp_*: result word (speed_cmd, distance, arrived), one per position word,
//          taken when rsp_valid && !rsp_stall.
//   csr_*: register writes, index/data, always ready; write only when idle.
// Sequence: one position word is worked on at a time: serial squaring (ST_SQ),
//   the bit-serial square root (ST_ROOT) and serial gain multiplies (ST_GAIN),
//   with the load states ST_SUM and ST_LOADG between them and ST_FIN last. A new
//   word is taken in the cycle after the result is registered, so a word is not
//   taken until the previous one is through.
// The output register holds a finished word while the receiver stalls; the
//   next position word is then already accepted and processed, and waits in
//   the finish state only if the output register is still occupied.
// Reset (synchronous): registers return to their defaults, the stored
//   velocity clears to zero, no result is pending.
module distance_velocity_controller_core
   import dvc_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  dvc_req_type             req_data,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output dvc_rsp_type             rsp_data,
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [CSR_INDEX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0]   csr_wdata
);

   typedef enum logic [6:0] {
      ST_IDLE  = 7'b0000001,
      ST_SQ    = 7'b0000010,
      ST_SUM   = 7'b0000100,
      ST_ROOT  = 7'b0001000,
      ST_LOADG = 7'b0010000,
      ST_GAIN  = 7'b0100000,
      ST_FIN   = 7'b1000000
   } dvc_state_type;

   dvc_state_type      state_ff, state_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;

   logic signed [15:0] target_x_ff;
   logic signed [15:0] target_y_ff;
   logic        [15:0] gain_p_ff;
   logic        [15:0] gain_damp_ff;
   logic        [14:0] max_speed_ff;
   logic        [15:0] arrive_thr_ff;
   logic signed [15:0] prev_speed_ff, prev_speed_in;

   logic               arrived_ff, arrived_in;
   logic        [16:0] dist_ff, dist_in;
   logic               rsp_valid_ff, rsp_valid_in;
   dvc_rsp_type        rsp_ff, rsp_in;

   logic signed [16:0] dx, dy;
   logic        [16:0] dx_abs, dy_abs;
   logic        [15:0] ax, ay;
   logic               accept;
   logic               out_free;

   dvc_seq_ctl_type    mul_ctl, root_ctl;
   logic signed [17:0] mcand_x, mcand_y;
   logic        [15:0] mplier_x, mplier_y;
   logic signed [33:0] prod_x, prod_y;
   logic        [33:0] radicand;
   logic        [16:0] root;

   logic signed [34:0] acc;
   logic signed [26:0] vel;
   logic signed [15:0] vel_sat;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         target_x_ff   <= '0;
         target_y_ff   <= '0;
         gain_p_ff     <= 16'd256;
         gain_damp_ff  <= '0;
         max_speed_ff  <= 15'd1000;
         arrive_thr_ff <= 16'd50;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_TARGET_X:   target_x_ff   <= csr_wdata;
            CSR_TARGET_Y:   target_y_ff   <= csr_wdata;
            CSR_GAIN_P:     gain_p_ff     <= csr_wdata;
            CSR_GAIN_DAMP:  gain_damp_ff  <= csr_wdata;
            CSR_MAX_SPEED:  max_speed_ff  <= csr_wdata[14:0];
            CSR_ARRIVE_THR: arrive_thr_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // axis errors, exact in 17 bits; magnitude fits 16
   always_comb begin
      dx     = {target_x_ff[15], target_x_ff} - {req_data.cur_x[15], req_data.cur_x};
      dy     = {target_y_ff[15], target_y_ff} - {req_data.cur_y[15], req_data.cur_y};
      dx_abs = dx[16] ? -dx : dx;
      dy_abs = dy[16] ? -dy : dy;
      ax     = dx_abs[15:0];
      ay     = dy_abs[15:0];
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   assign radicand = {1'b0, prod_x[32:0]} + {1'b0, prod_y[32:0]};

   // velocity: (gp*dist - gd*prev) >>> 8, clamped
   always_comb begin
      acc = {prod_x[33], prod_x} - {prod_y[33], prod_y};
      vel = acc[34:8];
      if (vel > $signed({12'd0, max_speed_ff})) begin
         vel_sat = {1'b0, max_speed_ff};
      end else if (vel < -27'sd32768) begin
         vel_sat = 16'sh8000;
      end else begin
         vel_sat = vel[15:0];
      end
   end

   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      mul_ctl       = '0;
      root_ctl      = '0;
      mcand_x       = {2'b00, ax};
      mcand_y       = {2'b00, ay};
      mplier_x      = ax;
      mplier_y      = ay;
      arrived_in    = arrived_ff;
      dist_in       = dist_ff;
      prev_speed_in = prev_speed_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_in        = rsp_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               mul_ctl.load = 1'b1;
               arrived_in   = (ax <= arrive_thr_ff) && (ay <= arrive_thr_ff);
               cnt_in       = '0;
               state_in     = ST_SQ;
            end
         end
         ST_SQ: begin
            mul_ctl.step = 1'b1;
            cnt_in       = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(MUL_STEPS - 1)) begin
               state_in = ST_SUM;
            end
         end
         ST_SUM: begin
            root_ctl.load = 1'b1;
            cnt_in        = '0;
            state_in      = ST_ROOT;
         end
         ST_ROOT: begin
            root_ctl.step = 1'b1;
            cnt_in        = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(ROOT_STEPS - 1)) begin
               state_in = ST_LOADG;
            end
         end
         ST_LOADG: begin
            mul_ctl.load = 1'b1;
            mcand_x      = {1'b0, root};
            mplier_x     = gain_p_ff;
            mcand_y      = {{2{prev_speed_ff[15]}}, prev_speed_ff};
            mplier_y     = gain_damp_ff;
            dist_in      = root;
            cnt_in       = '0;
            state_in     = ST_GAIN;
         end
         ST_GAIN: begin
            mul_ctl.step = 1'b1;
            cnt_in       = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(MUL_STEPS - 1)) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            if (out_free) begin
               prev_speed_in    = vel_sat;
               rsp_valid_in     = 1'b1;
               rsp_in.speed_cmd = vel_sat;
               rsp_in.distance  = dist_ff;
               rsp_in.arrived   = arrived_ff;
               state_in         = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         cnt_ff        <= '0;
         prev_speed_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cnt_ff        <= cnt_in;
         prev_speed_ff <= prev_speed_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      arrived_ff <= arrived_in;
      dist_ff    <= dist_in;
      rsp_ff     <= rsp_in;
   end

   dvc_smul u_mul_x (
      .clock   (clock),
      .ctl     (mul_ctl),
      .mcand   (mcand_x),
      .mplier  (mplier_x),
      .product (prod_x)
   );

   dvc_smul u_mul_y (
      .clock   (clock),
      .ctl     (mul_ctl),
      .mcand   (mcand_y),
      .mplier  (mplier_y),
      .product (prod_y)
   );

   dvc_sqrt u_sqrt (
      .clock    (clock),
      .ctl      (root_ctl),
      .radicand (radicand),
      .root     (root)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == ST_SQ)
      else $error("accepted word did not start squaring");

   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(ROOT_STEPS))
      else $error("step counter out of range");

   a_rsp_from_fin: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_FIN))
      else $error("result loaded outside finish state");

   a_fin_holds: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_FIN && rsp_valid_ff && rsp_stall |=> state_ff == ST_FIN)
      else $error("finished word dropped while output occupied");

   a_stall_busy: assert property (@(posedge clock) disable iff (reset)
      state_ff != ST_IDLE |-> req_stall)
      else $error("input open while busy");

endmodule

// File: src/dvc_smul.sv
// Radix-2 serial multiplier: 18-bit signed multiplicand, 16-bit unsigned
// multiplier, one multiplier bit per step, 34-bit signed product.
// Depends on dvc_pkg.
module dvc_smul
   import dvc_pkg::*;
(
   input  logic                clock,
   input  dvc_seq_ctl_type     ctl,
   input  logic signed [17:0]  mcand,
   input  logic        [15:0]  mplier,
   output logic signed [33:0]  product
);

   logic signed [17:0] hi_ff, hi_in;
   logic        [15:0] lo_ff, lo_in;
   logic signed [17:0] mcand_ff, mcand_in;
   logic        [18:0] sum;

   always_comb begin
      sum      = {hi_ff[17], hi_ff} + (lo_ff[0] ? {mcand_ff[17], mcand_ff} : 19'd0);
      hi_in    = hi_ff;
      lo_in    = lo_ff;
      mcand_in = mcand_ff;
      if (ctl.load) begin
         hi_in    = '0;
         lo_in    = mplier;
         mcand_in = mcand;
      end else if (ctl.step) begin
         hi_in = sum[18:1];
         lo_in = {sum[0], lo_ff[15:1]};
      end
   end

   always_ff @(posedge clock) begin
      hi_ff    <= hi_in;
      lo_ff    <= lo_in;
      mcand_ff <= mcand_in;
   end

   assign product = {hi_ff, lo_ff};

endmodule

// File: src/dvc_sqrt.sv
// Restoring integer square root, one root bit per step (17 steps for a
// 34-bit radicand). Depends on dvc_pkg.
module dvc_sqrt
   import dvc_pkg::*;
(
   input  logic             clock,
   input  dvc_seq_ctl_type  ctl,
   input  logic [33:0]      radicand,
   output logic [16:0]      root
);

   logic [33:0] rad_ff, rad_in;
   logic [17:0] rem_ff, rem_in;
   logic [16:0] root_ff, root_in;
   logic [19:0] rem_sh;
   logic [19:0] trial;
   logic [19:0] diff;

   always_comb begin
      rem_sh  = {rem_ff, rad_ff[33:32]};
      trial   = {1'b0, root_ff, 2'b01};
      diff    = rem_sh - trial;
      rad_in  = rad_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      if (ctl.load) begin
         rad_in  = radicand;
         rem_in  = '0;
         root_in = '0;
      end else if (ctl.step) begin
         rad_in = {rad_ff[31:0], 2'b00};
         if (rem_sh >= trial) begin
            rem_in  = diff[17:0];
            root_in = {root_ff[15:0], 1'b1};
         end else begin
            rem_in  = rem_sh[17:0];
            root_in = {root_ff[15:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   assign root = root_ff;

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for distance_velocity_controller_core: a directed table,
// then random phases of register settings and position words, all scored in order.
// Depends on dvc_pkg and the controller RTL.
module tb_top
   import dvc_pkg::*;
();

   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_6 = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_7 = 3'd7;
   localparam int DIR_ROWS = 44;

   typedef enum logic {ROW_POS, ROW_CSR} row_kind_type;

   typedef struct {
      row_kind_type           kind;
      logic [CSR_INDEX_W-1:0] idx;
      logic [CSR_DATA_W-1:0]  wdata;
      dvc_req_type            pos;
      logic                   has_want;
      dvc_rsp_type            want;
   } dir_row_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   dvc_req_type            req_data = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   dvc_rsp_type            rsp_data;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   // controller image kept by the testbench
   logic signed [15:0] aim_x = 16'sd0;
   logic signed [15:0] aim_y = 16'sd0;
   logic [15:0]        kp_gain = 16'd256;
   logic [15:0]        kd_gain = 16'd0;
   logic [14:0]        speed_cap = 15'd1000;
   logic [15:0]        arrive_tol = 16'd50;
   logic signed [15:0] last_speed = 16'sd0;

   dvc_rsp_type pending_cmds[$];
   dvc_rsp_type rsp_want;
   int          mismatch_count = 0;
   logic        gaps_on = 1'b1;

   dir_row_type dir_table [0:DIR_ROWS-1] = '{
      '{ROW_POS, '0, '0, {16'sd0, 16'sd0}, 1'b1, {16'sd0, 17'd0, 1'b1}},
      '{ROW_POS, '0, '0, {16'sd3, 16'sd4}, 1'b1, {16'sd5, 17'd5, 1'b1}},
      '{ROW_POS, '0, '0, {16'sd50, -16'sd50}, 1'b1, {16'sd70, 17'd70, 1'b1}},
      '{ROW_POS, '0, '0, {16'sd51, 16'sd0}, 1'b1, {16'sd51, 17'd51, 1'b0}},
      '{ROW_POS, '0, '0, {16'sh8000, 16'sh8000}, 1'b1, {16'sd1000, 17'd46340, 1'b0}},
      '{ROW_POS, '0, '0, {16'sh7FFF, 16'sh7FFF}, 1'b1, {16'sd1000, 17'd46339, 1'b0}},
      '{ROW_CSR, CSR_TARGET_X, 16'h7FFF, '0, 1'b0, '0},
      '{ROW_CSR, CSR_TARGET_Y, 16'h7FFF, '0, 1'b0, '0},
      '{ROW_POS, '0, '0, {16'sh8000, 16'sh8000}, 1'b1, {16'sd1000, 17'd92680, 1'b0}},
      '{ROW_CSR, CSR_TARGET_X, 16'h8000, '0, 1'b0, '0},
      '{ROW_POS, '0, '0, {16'sh7FFF, 16'sh7FFF}, 1'b1, {16'sd1000, 17'd65535, 1'b0}},
      '{ROW_CSR, CSR_ARRIVE_THR, 16'hFFFF, '0, 1'b0, '0},
      '{ROW_POS, '0, '0, {16'sh7FFF, 16'sh8000}, 1'b1, {16'sd1000, 17'd92680, 1'b1}},
      '{ROW_CSR, CSR_MAX_SPEED, 16'h7FFF, '0, 1'b0, '0},
      '{ROW_CSR, CSR_GAIN_P, 16'hFFFF, '0, 1'b0, '0},
      '{ROW_POS, '0, '0, {16'sh7FFF, 16'sh8000}, 1'b1, {16'sh7FFF, 17'd92680, 1'b1}},
      '{ROW_CSR, CSR_GAIN_P, 16'h0000, '0, 1'b0, '0},
      '{ROW_CSR, CSR_GAIN_DAMP, 16'hFFFF, '0, 1'b0, '0},
      '{ROW_CSR, CSR_TARGET_X, 16'h0000, '0, 1'b0, '0},
      '{ROW_CSR, CSR_TARGET_Y, 16'h0000, '0, 1'b0, '0},
      '{ROW_POS, '0, '0, {16'sd0, 16'sd0}, 1'b1, {16'sh8000, 17'd0, 1'b1}},
      '{ROW_POS, '0, '0, {16'sd0, 16'sd0}, 1'b1, {16'sh7FFF, 17'd0, 1'b1}},
      '{ROW_CSR, CSR_MAX_SPEED, 16'h0000, '0, 1'b0, '0},
      '{ROW_POS, '0, '0, {16'sd0, 16'sd0}, 1'b1, {16'sh8000, 17'd0, 1'b1}},
      '{ROW_POS, '0, '0, {16'sd100, 16'sd0}, 1'b1, {16'sd0, 17'd100, 1'b1}},
      '{ROW_CSR, CSR_GAIN_DAMP, 16'h0001, '0, 1'b0, '0},
      '{ROW_CSR, CSR_GAIN_P, 16'h0001, '0, 1'b0, '0},
      '{ROW_CSR, CSR_MAX_SPEED, 16'd1000, '0, 1'b0, '0},
      '{ROW_CSR, CSR_ARRIVE_THR, 16'h0000, '0, 1'b0, '0},
      '{ROW_POS, '0, '0, {16'sd0, 16'sd0}, 1'b1, {16'sd0, 17'd0, 1'b1}},
      '{ROW_POS, '0, '0, {16'sd0, 16'sd3}, 1'b1, {16'sd0, 17'd3, 1'b0}},
      '{ROW_CSR, CSR_GAIN_P, 16'h0100, '0, 1'b0, '0},
      '{ROW_POS, '0, '0, {16'sd0, 16'sd7}, 1'b1, {16'sd7, 17'd7, 1'b0}},
      '{ROW_POS, '0, '0, {16'sd0, 16'sd0}, 1'b1, {16'shFFFF, 17'd0, 1'b1}},
      '{ROW_POS, '0, '0, {16'sd0, 16'sd0}, 1'b1, {16'sd0, 17'd0, 1'b1}},
      '{ROW_CSR, CSR_SPARE_6, 16'hFFFF, '0, 1'b0, '0},
      '{ROW_CSR, CSR_SPARE_7, 16'hFFFF, '0, 1'b0, '0},
      '{ROW_POS, '0, '0, {16'sd3, 16'sd4}, 1'b1, {16'sd5, 17'd5, 1'b0}},
      '{ROW_CSR, CSR_ARRIVE_THR, 16'd50, '0, 1'b0, '0},
      '{ROW_CSR, CSR_TARGET_X, 16'd1234, '0, 1'b0, '0},
      '{ROW_CSR, CSR_TARGET_Y, -16'sd777, '0, 1'b0, '0},
      '{ROW_CSR, CSR_GAIN_DAMP, 16'h0080, '0, 1'b0, '0},
      '{ROW_POS, '0, '0, {16'sd1200, -16'sd800}, 1'b0, '0},
      '{ROW_POS, '0, '0, {-16'sd5000, 16'sd300}, 1'b0, '0}
   };

   distance_velocity_controller_core uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // next velocity command; updates the stored velocity
   function automatic dvc_rsp_type predict_motion(input dvc_req_type pos);
      logic signed [16:0] dx, dy;
      logic [16:0]        ax, ay;
      logic [63:0]        sq, root, probe;
      longint             acc, vel;
      dvc_rsp_type        cmd;
      dx = {aim_x[15], aim_x} - {pos.cur_x[15], pos.cur_x};
      dy = {aim_y[15], aim_y} - {pos.cur_y[15], pos.cur_y};
      ax = dx[16] ? 17'(-dx) : 17'(dx);
      ay = dy[16] ? 17'(-dy) : 17'(dy);
      sq = 64'(ax) * 64'(ax) + 64'(ay) * 64'(ay);
      root = '0;
      probe = 64'd1 << 62;
      while (probe > sq) probe = probe >> 2;
      while (probe != 0) begin
         if (sq >= root + probe) begin
            sq = sq - (root + probe);
            root = (root >> 1) + probe;
         end else begin
            root = root >> 1;
         end
         probe = probe >> 2;
      end
      acc = $signed({48'd0, kp_gain}) * $signed({47'd0, root[16:0]})
          - $signed({48'd0, kd_gain}) * longint'(last_speed);
      vel = acc >>> 8;
      if (vel > $signed({49'd0, speed_cap})) vel = $signed({49'd0, speed_cap});
      if (vel < -32768) vel = -32768;
      last_speed = vel[15:0];
      cmd.speed_cmd = last_speed;
      cmd.distance = root[16:0];
      cmd.arrived = (ax <= {1'b0, arrive_tol}) && (ay <= {1'b0, arrive_tol});
      return cmd;
   endfunction

   function automatic logic [15:0] pick_coord();
      case ($urandom_range(0, 3))
         0: return 16'h8000;
         1: return 16'h7FFF;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic [15:0] pick_gain();
      case ($urandom_range(0, 4))
         0: return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
         1: return 16'($urandom_range(0, 64));
         2: return 16'($urandom_range(0, 512));
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic send_pos(input dvc_req_type pos, input logic has_want,
                           input dvc_rsp_type want);
      int          gap;
      int          r;
      dvc_rsp_type cmd;
      r = $urandom_range(0, 99);
      if (!gaps_on || r < 40) gap = 0;
      else if (r < 85) gap = $urandom_range(1, 3);
      else if (r < 97) gap = $urandom_range(4, 15);
      else gap = $urandom_range(20, 120);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= pos;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      cmd = predict_motion(pos);
      pending_cmds.push_back(has_want ? want : cmd);
   endtask

   // registers change only with the controller drained
   task automatic write_csr(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      req_valid <= 1'b0;
      while (pending_cmds.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      case (idx)
         CSR_TARGET_X:   aim_x = data;
         CSR_TARGET_Y:   aim_y = data;
         CSR_GAIN_P:     kp_gain = data;
         CSR_GAIN_DAMP:  kd_gain = data;
         CSR_MAX_SPEED:  speed_cap = data[14:0];
         CSR_ARRIVE_THR: arrive_tol = data;
         default: ;
      endcase
   endtask

   task automatic log_mismatch(input string msg);
      mismatch_count++;
      if (mismatch_count <= 10) $display("%s", msg);
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_cmds.size() == 0) begin
            log_mismatch($sformatf("unexpected rsp word: speed %0d dist %0d arr %0b",
               rsp_data.speed_cmd, rsp_data.distance, rsp_data.arrived));
         end else begin
            rsp_want = pending_cmds.pop_front();
            if (rsp_data.speed_cmd !== rsp_want.speed_cmd ||
                rsp_data.distance !== rsp_want.distance ||
                rsp_data.arrived !== rsp_want.arrived) begin
               log_mismatch($sformatf(
                  "rsp mismatch: exp speed %0d dist %0d arr %0b, got speed %0d dist %0d arr %0b",
                  rsp_want.speed_cmd, rsp_want.distance, rsp_want.arrived,
                  rsp_data.speed_cmd, rsp_data.distance, rsp_data.arrived));
            end
         end
      end
   end

   // receiver back-pressure: short bursts, rare long ones, quiet stretches
   initial begin
      int r, n_on, n_off;
      forever begin
         r = $urandom_range(0, 99);
         if (r < 10) begin
            n_on = 0;
            n_off = $urandom_range(100, 400);
         end else begin
            n_on = (r < 94) ? $urandom_range(1, 3) : $urandom_range(20, 150);
            n_off = $urandom_range(1, 8);
         end
         repeat (n_on) begin
            @(posedge clock);
            rsp_stall <= 1'b1;
         end
         repeat (n_off) begin
            @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   initial begin
      int          k, phase, spread, off_x, off_y;
      dvc_req_type pos;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      for (k = 0; k < DIR_ROWS; k++) begin
         if (dir_table[k].kind == ROW_CSR) begin
            write_csr(dir_table[k].idx, dir_table[k].wdata);
         end else begin
            send_pos(dir_table[k].pos, dir_table[k].has_want, dir_table[k].want);
         end
      end

      for (phase = 0; phase < 9; phase++) begin
         write_csr(CSR_TARGET_X, pick_coord());
         write_csr(CSR_TARGET_Y, pick_coord());
         write_csr(CSR_GAIN_P, pick_gain());
         write_csr(CSR_GAIN_DAMP, pick_gain());
         case ($urandom_range(0, 3))
            0: write_csr(CSR_MAX_SPEED, $urandom_range(0, 1) ? 16'hFFFF : 16'h8000);
            1: write_csr(CSR_MAX_SPEED, 16'($urandom_range(0, 2000)));
            default: write_csr(CSR_MAX_SPEED, 16'($urandom));
         endcase
         case ($urandom_range(0, 3))
            0: write_csr(CSR_ARRIVE_THR, $urandom_range(0, 1) ? 16'hFFFF : 16'h0000);
            1: write_csr(CSR_ARRIVE_THR, 16'($urandom));
            default: write_csr(CSR_ARRIVE_THR, 16'($urandom_range(0, 200)));
         endcase
         if ($urandom_range(0, 2) == 0) begin
            write_csr($urandom_range(0, 1) ? CSR_SPARE_6 : CSR_SPARE_7, 16'($urandom));
         end
         gaps_on = ($urandom_range(0, 3) != 0);
         repeat ($urandom_range(80, 120)) begin
            if ($urandom_range(0, 9) < 7) begin
               spread = $urandom_range(0, 1) ? 300 : 3000;
               off_x = $urandom_range(0, 2 * spread) - spread;
               off_y = $urandom_range(0, 2 * spread) - spread;
               pos.cur_x = aim_x + 16'(off_x);
               pos.cur_y = aim_y + 16'(off_y);
            end else begin
               pos = $urandom;
            end
            send_pos(pos, 1'b0, '0);
         end
      end

      req_valid <= 1'b0;
      while (pending_cmds.size() != 0) @(posedge clock);
      repeat (80) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

   initial begin
      #15_000_000;
      $display("TB_ERROR");
      $finish;
   end

endmodule

// File: distance_velocity_controller_core.f
src/dvc_pkg.sv
src/dvc_smul.sv
src/dvc_sqrt.sv
src/distance_velocity_controller_core.sv
tb/tb_top.sv
